// ----- hdl/cva_pkg.sv -----
// cva_pkg: shared constants, register indexes and word types for the
// vertex value assignment block; no dependencies
package cva_pkg;

    localparam int ID_BITS          = 12;
    localparam int WORD_BITS        = 16;
    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int VALUE_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH      = 4;
    // fixed-point scale of the reciprocal used to fold ids into the store
    localparam int RECIP_SHIFT      = 2 * ID_BITS;

    localparam logic [WORD_BITS-1:0] EDGE_COUNT_RST = 16'd1;
    localparam logic [WORD_BITS-1:0] INDEX_MASK_RST = 16'hFFFF;

    typedef enum logic [0:0] {
        REG_EDGE_COUNT = 1'b0,
        REG_INDEX_MASK = 1'b1
    } cva_reg_idx_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] edge_number;
        logic [ID_BITS-1:0]   vertex_first;
        logic [ID_BITS-1:0]   vertex_second;
        logic                 last_edge;
    } cva_in_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   written_vertex;
        logic [WORD_BITS-1:0] written_value;
        logic                 wrote_first;
        logic                 done_res;
    } cva_out_t;

endpackage

// ----- hdl/cva_front.sv -----
// cva_front: accepts edge words and folds both vertex ids into store slots
// over two pipeline stages; depends on cva_pkg
module cva_front #(
    parameter  int VERTEX_COUNT = cva_pkg::VERTEX_COUNT_DEF,
    localparam int SLOT_BITS    = $clog2(VERTEX_COUNT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  edge_valid,
    output logic                  edge_ready,
    input  cva_pkg::cva_in_t      edge_word,
    input  logic                  hold,
    output logic                  push_valid,
    input  logic                  push_ready,
    output cva_pkg::cva_in_t      push_item,
    output logic [SLOT_BITS-1:0]  push_slot_first,
    output logic [SLOT_BITS-1:0]  push_slot_second
);
    import cva_pkg::*;

    localparam int PROD_BITS = ID_BITS + RECIP_SHIFT;
    localparam int MOD_BITS  = $clog2(VERTEX_COUNT) + 1;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / VERTEX_COUNT);
    localparam logic [MOD_BITS-1:0] MODV = MOD_BITS'(VERTEX_COUNT);

    // remainder estimate is at most one modulus too large
    function automatic logic [SLOT_BITS-1:0] fold(logic [ID_BITS-1:0] id,
                                                  logic [ID_BITS-1:0] qn);
        logic [ID_BITS-1:0] r;
        r = id - qn;
        if (32'(r) >= VERTEX_COUNT)
        begin
            r = r - ID_BITS'(VERTEX_COUNT);
        end
        return SLOT_BITS'(r);
    endfunction

    logic                 st1_valid_reg, st1_valid_next;
    cva_in_t              st1_item_reg;
    logic [ID_BITS-1:0]   st1_quot_a_reg, st1_quot_b_reg;
    logic                 st2_valid_reg, st2_valid_next;
    cva_in_t              st2_item_reg;
    logic [ID_BITS-1:0]   st2_qn_a_reg, st2_qn_b_reg;

    logic [PROD_BITS-1:0] prod_a, prod_b;
    logic                 st1_ready, st2_ready, take, st1_move;

    assign prod_a = PROD_BITS'(edge_word.vertex_first)  * PROD_BITS'(RECIP);
    assign prod_b = PROD_BITS'(edge_word.vertex_second) * PROD_BITS'(RECIP);

    assign st2_ready  = !st2_valid_reg || push_ready;
    assign st1_ready  = !st1_valid_reg || st2_ready;
    assign edge_ready = st1_ready && !hold;
    assign take       = edge_valid && edge_ready;
    assign st1_move   = st1_valid_reg && st2_ready;

    assign st1_valid_next = take || (st1_valid_reg && !st2_ready);
    assign st2_valid_next = st1_move || (st2_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end
        else
        begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            st1_item_reg   <= edge_word;
            st1_quot_a_reg <= prod_a[PROD_BITS-1:RECIP_SHIFT];
            st1_quot_b_reg <= prod_b[PROD_BITS-1:RECIP_SHIFT];
        end
        if (st1_move)
        begin
            st2_item_reg <= st1_item_reg;
            st2_qn_a_reg <= ID_BITS'(st1_quot_a_reg * MODV);
            st2_qn_b_reg <= ID_BITS'(st1_quot_b_reg * MODV);
        end
    end

    assign push_valid       = st2_valid_reg;
    assign push_item        = st2_item_reg;
    assign push_slot_first  = fold(st2_item_reg.vertex_first, st2_qn_a_reg);
    assign push_slot_second = fold(st2_item_reg.vertex_second, st2_qn_b_reg);

endmodule

// ----- hdl/cva_queue.sv -----
// cva_queue: small first-in first-out buffer between the front and the back
// no package dependency beyond the default depth from cva_pkg
module cva_queue #(
    parameter int DATA_BITS = 1,
    parameter int DEPTH     = cva_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output logic [DATA_BITS-1:0] pop_data
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] slot_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 push, pop;

    assign push_ready = (32'(count_reg) < DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("queue occupancy beyond depth");

endmodule

// ----- hdl/cva_back.sv -----
// cva_back: vertex value and visited stores, read-modify-write with
// forwarding, clearing pass after reset and the result register; uses cva_pkg
module cva_back #(
    parameter  int VERTEX_COUNT = cva_pkg::VERTEX_COUNT_DEF,
    parameter  int VALUE_BITS   = cva_pkg::VALUE_BITS_DEF,
    localparam int SLOT_BITS    = $clog2(VERTEX_COUNT)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  cva_pkg::cva_in_t              q_item,
    input  logic [SLOT_BITS-1:0]          q_slot_first,
    input  logic [SLOT_BITS-1:0]          q_slot_second,
    input  logic [cva_pkg::WORD_BITS-1:0] edge_count,
    input  logic [cva_pkg::WORD_BITS-1:0] index_mask,
    output logic                          result_valid,
    input  logic                          result_ready,
    output cva_pkg::cva_out_t             result_word,
    output logic                          busy
);
    import cva_pkg::*;

    localparam int MEM_BITS = VALUE_BITS + 1;

    // value store word: {touched mark, value}; second store marks second-position ids
    logic [MEM_BITS-1:0]   val_mem  [VERTEX_COUNT];
    logic                  seen_mem [VERTEX_COUNT];

    logic                  clr_busy_reg;
    logic [SLOT_BITS-1:0]  clr_addr_reg;

    logic                  x_valid_reg, x_valid_next;
    cva_in_t               x_item_reg;
    logic [SLOT_BITS-1:0]  x_s1_reg, x_s2_reg;
    logic [MEM_BITS-1:0]   rd_first_reg;
    logic [VALUE_BITS-1:0] rd_second_reg;
    logic                  rd_seen_reg;

    logic                  fwd_valid_reg;
    logic [SLOT_BITS-1:0]  fwd_val_slot_reg, fwd_seen_slot_reg;
    logic [VALUE_BITS-1:0] fwd_val_reg;

    logic                  res_valid_reg, res_valid_next;
    cva_out_t              res_word_reg;

    logic                  advance;
    logic [VALUE_BITS-1:0] val_first, val_second, base, mask, value;
    logic                  mark_first, seenb_first, take_first;
    logic [SLOT_BITS-1:0]  target_slot;
    logic                  val_we, seen_we, seen_wdata;
    logic [SLOT_BITS-1:0]  val_waddr, seen_waddr;
    logic [MEM_BITS-1:0]   val_wdata;

    assign advance        = x_valid_reg && (!res_valid_reg || result_ready);
    assign q_pop          = q_valid && !clr_busy_reg && (!x_valid_reg || advance);
    assign x_valid_next   = q_pop || (x_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && !result_ready);

    // only the write made in the cycle of the read can be missing from the read data
    always_comb
    begin
        val_first   = rd_first_reg[VALUE_BITS-1:0];
        mark_first  = rd_first_reg[VALUE_BITS];
        val_second  = rd_second_reg;
        seenb_first = rd_seen_reg;
        if (fwd_valid_reg)
        begin
            if (fwd_val_slot_reg == x_s1_reg)
            begin
                val_first  = fwd_val_reg;
                mark_first = 1'b1;
            end
            if (fwd_val_slot_reg == x_s2_reg)
            begin
                val_second = fwd_val_reg;
            end
            if (fwd_seen_slot_reg == x_s1_reg)
            begin
                seenb_first = 1'b1;
            end
        end
        base       = VALUE_BITS'(17'(edge_count) + 17'(x_item_reg.edge_number));
        mask       = VALUE_BITS'(index_mask);
        take_first = !(mark_first || seenb_first);
        if (take_first)
        begin
            value       = (base - val_second) & mask;
            target_slot = x_s1_reg;
        end
        else
        begin
            value       = (base - val_first) & mask;
            target_slot = x_s2_reg;
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            val_we     = 1'b1;
            val_waddr  = clr_addr_reg;
            val_wdata  = '0;
            seen_we    = 1'b1;
            seen_waddr = clr_addr_reg;
            seen_wdata = 1'b0;
        end
        else
        begin
            val_we     = advance;
            val_waddr  = target_slot;
            val_wdata  = {1'b1, value};
            seen_we    = advance;
            seen_waddr = x_s2_reg;
            seen_wdata = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (q_pop)
        begin
            rd_first_reg  <= val_mem[q_slot_first];
            rd_second_reg <= val_mem[q_slot_second][VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        if (q_pop)
        begin
            rd_seen_reg <= seen_mem[q_slot_first];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            x_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == SLOT_BITS'(VERTEX_COUNT - 1))
                begin
                    clr_busy_reg <= 1'b0;
                    clr_addr_reg <= '0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
            x_valid_reg   <= x_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            x_item_reg <= q_item;
            x_s1_reg   <= q_slot_first;
            x_s2_reg   <= q_slot_second;
        end
        if (advance)
        begin
            fwd_val_slot_reg            <= target_slot;
            fwd_seen_slot_reg           <= x_s2_reg;
            fwd_val_reg                 <= value;
            res_word_reg.written_vertex <= take_first ? x_item_reg.vertex_first
                                                      : x_item_reg.vertex_second;
            res_word_reg.written_value  <= WORD_BITS'(value);
            res_word_reg.wrote_first    <= take_first;
            res_word_reg.done_res       <= x_item_reg.last_edge;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_word  = res_word_reg;
    assign busy         = clr_busy_reg;

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !q_pop)
        else $error("edge taken from queue during clearing pass");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> (!x_valid_reg && !res_valid_reg))
        else $error("work in flight during clearing pass");

    a_fwd_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (fwd_valid_reg && fwd_seen_slot_reg == $past(x_s2_reg)))
        else $error("forwarding register missed a write");

    a_clear_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> (clr_addr_reg == '0))
        else $error("clearing pass ended off its last entry");

endmodule

// ----- hdl/chm_vertex_value_assign.sv -----
// chm_vertex_value_assign: top level of the vertex value assignment block
// holds the configuration registers and joins cva_front, cva_queue and cva_back
//
// Usage:
//   Edge words enter on edge_valid/edge_ready/edge_word in peeling order; one
//   result word per edge leaves on result_valid/result_ready/result_word, in
//   the same order. cfg_wr_en writes cfg_data into the register named by
//   cfg_index (edge count, index mask) at the clock edge, no wait states;
//   write it only while no edge is in flight.
//   An edge passes the two front stages, the queue, the back end read stage
//   and the result register. Throughput: one edge per cycle while the
//   receiver takes results; the value store does one read-modify-write per
//   cycle, with the previous write forwarded. Reset: both stores are swept to
//   zero, one entry per cycle, after rst_n rises; edge_ready is low meanwhile.
//   Receiver stall: the result register holds its word; the queue between
//   the slot folding front and the store back end keeps taking edges until
//   it and the front pipeline fill, then edge_ready drops.
module chm_vertex_value_assign #(
    parameter int VERTEX_COUNT = cva_pkg::VERTEX_COUNT_DEF,
    parameter int VALUE_BITS   = cva_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          edge_valid,
    output logic                          edge_ready,
    input  cva_pkg::cva_in_t              edge_word,
    output logic                          result_valid,
    input  logic                          result_ready,
    output cva_pkg::cva_out_t             result_word,
    input  logic                          cfg_wr_en,
    input  cva_pkg::cva_reg_idx_t         cfg_index,
    input  logic [cva_pkg::WORD_BITS-1:0] cfg_data
);
    import cva_pkg::*;

    localparam int SLOT_BITS = $clog2(VERTEX_COUNT);
    localparam int Q_BITS    = $bits(cva_in_t) + 2 * SLOT_BITS;

    logic [WORD_BITS-1:0] edge_count_reg, index_mask_reg;

    logic                 push_valid, push_ready, pop_valid, pop_ready, busy;
    cva_in_t              push_item, pop_item;
    logic [SLOT_BITS-1:0] push_s1, push_s2, pop_s1, pop_s2;
    logic [Q_BITS-1:0]    pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= EDGE_COUNT_RST;
            index_mask_reg <= INDEX_MASK_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_EDGE_COUNT: edge_count_reg <= cfg_data;
                REG_INDEX_MASK: index_mask_reg <= cfg_data;
            endcase
        end
    end

    cva_front #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .edge_valid       (edge_valid),
        .edge_ready       (edge_ready),
        .edge_word        (edge_word),
        .hold             (busy),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_item        (push_item),
        .push_slot_first  (push_s1),
        .push_slot_second (push_s2)
    );

    cva_queue #(
        .DATA_BITS(Q_BITS),
        .DEPTH    (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_item, push_s1, push_s2}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {pop_item, pop_s1, pop_s2} = pop_data;

    cva_back #(
        .VERTEX_COUNT(VERTEX_COUNT),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (pop_valid),
        .q_pop         (pop_ready),
        .q_item        (pop_item),
        .q_slot_first  (pop_s1),
        .q_slot_second (pop_s2),
        .edge_count    (edge_count_reg),
        .index_mask    (index_mask_reg),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_word   (result_word),
        .busy          (busy)
    );

endmodule

// ----- test/chm_vertex_value_assign_tb.sv -----
`timescale 1ns / 1ps
// chm_vertex_value_assign_tb: self-checking bench for the vertex value assignment block
// needs cva_pkg and chm_vertex_value_assign; a local shadow of the value and
// visited stores predicts each result word not given typed in a directed row
module chm_vertex_value_assign_tb;

    import cva_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 173;
    localparam int RECENT      = 64;

    typedef struct {
        cva_in_t  word;
        bit       typed;
        cva_out_t want;
    } edge_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 edge_valid;
    logic                 edge_ready;
    cva_in_t              edge_word;
    logic                 result_valid;
    logic                 result_ready;
    cva_out_t             result_word;
    logic                 cfg_wr_en;
    cva_reg_idx_t         cfg_index;
    logic [WORD_BITS-1:0] cfg_data;

    // shadow of the block state
    logic [WORD_BITS-1:0] shadow_value [VERTEX_COUNT_DEF];
    bit                   shadow_seen  [VERTEX_COUNT_DEF];
    logic [WORD_BITS-1:0] shadow_edge_count;
    logic [WORD_BITS-1:0] shadow_mask;

    cva_out_t             pending_results [$];
    edge_row_t            directed_rows [11];
    logic [ID_BITS-1:0]   recent_ids [RECENT];
    int                   recent_wr;
    int                   mismatch_count;
    bit                   calm;

    chm_vertex_value_assign i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_ready   (edge_ready),
        .edge_word    (edge_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("chm_vertex_value_assign_tb failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // one peeling step: write whichever vertex is still free
    function automatic cva_out_t assign_vertex(cva_in_t w);
        logic [31:0] base;
        logic [31:0] val;
        cva_out_t    r;
        base = 32'(shadow_edge_count) + 32'(w.edge_number);
        if (!shadow_seen[w.vertex_first])
        begin
            val = (base - 32'(shadow_value[w.vertex_second])) & 32'(shadow_mask);
            shadow_value[w.vertex_first] = val[WORD_BITS-1:0];
            r.written_vertex = w.vertex_first;
            r.wrote_first    = 1'b1;
        end
        else
        begin
            val = (base - 32'(shadow_value[w.vertex_first])) & 32'(shadow_mask);
            shadow_value[w.vertex_second] = val[WORD_BITS-1:0];
            r.written_vertex = w.vertex_second;
            r.wrote_first    = 1'b0;
        end
        shadow_seen[w.vertex_first]  = 1'b1;
        shadow_seen[w.vertex_second] = 1'b1;
        r.written_value = val[WORD_BITS-1:0];
        r.done_res      = w.last_edge;
        return r;
    endfunction

    // mostly tree growth off recently touched vertices, plus tight reuse,
    // self loops and plain noise
    function automatic cva_in_t next_edge();
        int                 pick;
        logic [ID_BITS-1:0] old_id;
        logic [ID_BITS-1:0] fresh;
        cva_in_t            w;
        pick          = $urandom_range(0, 99);
        old_id        = recent_ids[$urandom_range(0, RECENT - 1)];
        fresh         = ID_BITS'($urandom);
        w.edge_number = WORD_BITS'($urandom);
        w.last_edge   = ($urandom_range(0, 15) == 0);
        if (pick < 60)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                w.vertex_first  = old_id;
                w.vertex_second = fresh;
            end
            else
            begin
                w.vertex_first  = fresh;
                w.vertex_second = old_id;
            end
        end
        else if (pick < 75)
        begin
            w.vertex_first  = old_id + ID_BITS'($urandom_range(0, 7));
            w.vertex_second = old_id + ID_BITS'($urandom_range(0, 7));
        end
        else if (pick < 85)
        begin
            w.vertex_first  = ($urandom_range(0, 1) != 0) ? old_id : fresh;
            w.vertex_second = w.vertex_first;
        end
        else
        begin
            w.vertex_first  = fresh;
            w.vertex_second = ID_BITS'($urandom);
        end
        recent_ids[recent_wr]                = w.vertex_first;
        recent_ids[(recent_wr + 1) % RECENT] = w.vertex_second;
        recent_wr = (recent_wr + 2) % RECENT;
        return w;
    endfunction

    task automatic send_edge(input cva_in_t w, input bit typed, input cva_out_t want);
        int       gap;
        cva_out_t predicted;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            edge_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        edge_valid <= 1'b1;
        edge_word  <= w;
        do @(posedge clk); while (!edge_ready);
        predicted = assign_vertex(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // hold off the sender until every pending word is back
    task automatic wait_idle();
        @(negedge clk);
        edge_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cva_reg_idx_t idx, input logic [WORD_BITS-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_EDGE_COUNT: shadow_edge_count = data;
            REG_INDEX_MASK: shadow_mask       = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        cva_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result word with nothing pending", 32'(result_word),
                                32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (result_word.written_vertex !== want.written_vertex)
                    report_mismatch("written_vertex", 32'(result_word.written_vertex),
                                    32'(want.written_vertex));
                if (result_word.written_value !== want.written_value)
                    report_mismatch("written_value", 32'(result_word.written_value),
                                    32'(want.written_value));
                if (result_word.wrote_first !== want.wrote_first)
                    report_mismatch("wrote_first", 32'(result_word.wrote_first),
                                    32'(want.wrote_first));
                if (result_word.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(result_word.done_res),
                                    32'(want.done_res));
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        result_ready = 1'b0;
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial
    begin : stimulus
        logic [WORD_BITS-1:0] phase_count [PHASES];
        logic [WORD_BITS-1:0] phase_mask  [PHASES];
        cva_out_t             no_want;

        rst_n        = 1'b0;
        edge_valid   = 1'b0;
        edge_word    = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_EDGE_COUNT;
        cfg_data     = '0;
        calm         = 1'b0;
        recent_wr    = 0;
        mismatch_count    = 0;
        no_want           = '0;
        shadow_edge_count = EDGE_COUNT_RST;
        shadow_mask       = INDEX_MASK_RST;
        for (int i = 0; i < VERTEX_COUNT_DEF; i++)
        begin
            shadow_value[i] = '0;
            shadow_seen[i]  = 1'b0;
        end
        for (int i = 0; i < RECENT; i++)
            recent_ids[i] = ID_BITS'($urandom);

        // typed rows assume the reset register values
        directed_rows = '{
            '{'{16'h0000, 12'h000, 12'h001, 1'b0}, 1'b1, '{12'h000, 16'h0001, 1'b1, 1'b0}},
            // largest edge number wraps to zero, final edge
            '{'{16'hFFFF, 12'hFFF, 12'hFFE, 1'b1}, 1'b1, '{12'hFFF, 16'h0000, 1'b1, 1'b1}},
            // first already seen, second gets the value
            '{'{16'h0005, 12'h000, 12'h002, 1'b0}, 1'b1, '{12'h002, 16'h0005, 1'b0, 1'b0}},
            // self loop, fresh then revisited with a negative difference
            '{'{16'h0007, 12'h003, 12'h003, 1'b0}, 1'b1, '{12'h003, 16'h0008, 1'b1, 1'b0}},
            '{'{16'h0002, 12'h003, 12'h003, 1'b0}, 1'b1, '{12'h003, 16'hFFFB, 1'b0, 1'b0}},
            '{'{16'h000A, 12'hFFF, 12'h005, 1'b0}, 1'b1, '{12'h005, 16'h000B, 1'b0, 1'b0}},
            '{'{16'h0000, 12'hAAA, 12'h002, 1'b0}, 1'b1, '{12'hAAA, 16'hFFFC, 1'b1, 1'b0}},
            '{'{16'hAAAA, 12'h555, 12'hAAA, 1'b0}, 1'b0, no_want},
            '{'{16'h5555, 12'hAAA, 12'h555, 1'b1}, 1'b0, no_want},
            '{'{16'h8000, 12'h800, 12'h7FF, 1'b0}, 1'b0, no_want},
            '{'{16'h0001, 12'h001, 12'h800, 1'b0}, 1'b0, no_want}
        };

        phase_count = '{16'hFFFF, 16'hFFFF, 16'h0001, 16'h0400, 16'h0001, 16'h0001};
        phase_mask  = '{16'h0000, 16'hFFFF, 16'h0001, 16'h03FF, 16'h0000, 16'hFFFF};
        phase_count[4] = WORD_BITS'($urandom_range(1, 65535));
        phase_mask[4]  = WORD_BITS'($urandom);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_edge(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_reg(REG_EDGE_COUNT, phase_count[p]);
            write_reg(REG_INDEX_MASK, phase_mask[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // a back-to-back stretch in every phase
                calm = (i >= 50 && i < 90);
                send_edge(next_edge(), 1'b0, no_want);
            end
            calm = 1'b0;
        end

        @(negedge clk);
        edge_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("chm_vertex_value_assign_tb passed");
        else
            $display("chm_vertex_value_assign_tb failed");
        $finish;
    end

endmodule
